// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define MSM_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, also checked around reset.
`define MSM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/msm_pkg.sv =====
`default_nettype none

package msm_pkg;

  localparam int ENCODER_COUNTS_DEF = 8192;

  localparam int ANGLE_W    = 13;
  localparam int MS_W       = 16;
  localparam int SPEED_W    = 16;
  localparam int LIMIT_W    = 15;
  localparam int COUNT_W    = 16;
  localparam int TICK_LIM_W = 13;  // stall_limit / 10 fits in 13 bits
  localparam int POS_W      = 32;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [MS_W-1:0]    OFFLINE_LIMIT_RST = MS_W'(50);
  localparam logic [LIMIT_W-1:0] STOP_SPEED_RST    = LIMIT_W'(50);

  typedef enum logic [1:0] {
    ST_OFFLINE = 2'd0,
    ST_STOP    = 2'd1,
    ST_RUNNING = 2'd2,
    ST_STALL   = 2'd3
  } motor_state_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STALL_ENABLE     = 3'd0,
    REG_STALL_THRESHOLD  = 3'd1,
    REG_STALL_LIMIT      = 3'd2,
    REG_POSITION_ENABLE  = 3'd3,
    REG_OFFLINE_LIMIT    = 3'd4,
    REG_STOP_SPEED_LIMIT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                  stall_en;
    logic [LIMIT_W-1:0]    stall_thr;
    logic [TICK_LIM_W-1:0] stall_tick_lim;
    logic                  pos_en;
    logic [MS_W-1:0]       offline_lim;
    logic [LIMIT_W-1:0]    stop_lim;
  } msm_cfg_t;

  typedef struct packed {
    motor_state_t        status;
    logic [COUNT_W-1:0]  stall_count;
  } status_upd_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] prior_angle;
    logic [POS_W-1:0]   turn_position;
  } pos_upd_t;

endpackage

`default_nettype wire

// ===== rtl/msm_status.sv =====
`default_nettype none

// Status tick: offline timeout, stop/running split, stall counter.
module msm_status (
  input  var msm_pkg::msm_cfg_t               cfg,
  input  var msm_pkg::motor_state_t           status_in,
  input  wire [msm_pkg::COUNT_W-1:0]          stall_count_in,
  input  wire [msm_pkg::MS_W-1:0]             elapsed_ms,
  input  wire signed [msm_pkg::SPEED_W-1:0]   speed,
  input  wire signed [msm_pkg::SPEED_W-1:0]   stall_value,
  output msm_pkg::status_upd_t                upd
);
  import msm_pkg::*;

  function automatic logic [SPEED_W:0] mag16(input logic signed [SPEED_W-1:0] v);
    logic [SPEED_W:0] ext;
    ext = {v[SPEED_W-1], v};
    return v[SPEED_W-1] ? ((SPEED_W+1)'(0) - ext) : ext;
  endfunction

  logic [SPEED_W:0]   spd_mag;
  logic [SPEED_W:0]   sv_mag;
  logic               offline;
  logic               stopped;
  logic               stall_cond;
  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W-1:0] lim_ext;

  always_comb begin
    spd_mag    = mag16(speed);
    sv_mag     = mag16(stall_value);
    offline    = elapsed_ms > cfg.offline_lim;
    stopped    = spd_mag < {2'b00, cfg.stop_lim};
    stall_cond = stopped && (sv_mag > {2'b00, cfg.stall_thr});
    cnt_inc    = (stall_count_in == {COUNT_W{1'b1}}) ? stall_count_in
                                                     : stall_count_in + COUNT_W'(1);
    lim_ext    = {{(COUNT_W-TICK_LIM_W){1'b0}}, cfg.stall_tick_lim};

    upd.status      = status_in;
    upd.stall_count = stall_count_in;
    if (offline) begin
      upd.status = ST_OFFLINE;
    end else if (!cfg.stall_en) begin
      upd.status = stopped ? ST_STOP : ST_RUNNING;
    end else if (stall_cond) begin
      if (cnt_inc >= lim_ext) begin
        upd.stall_count = lim_ext;
        upd.status      = ST_STALL;
      end else begin
        upd.stall_count = cnt_inc;
        upd.status      = ST_STOP;
      end
    end else begin
      // stall check enabled but not met: running even when stopped
      upd.stall_count = '0;
      upd.status      = ST_RUNNING;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/msm_unwrap.sv =====
`default_nettype none

// Angle sample: unwrap the single-turn angle into the multi-turn position.
module msm_unwrap #(
  parameter int ENCODER_COUNTS = msm_pkg::ENCODER_COUNTS_DEF
) (
  input  var msm_pkg::motor_state_t       status_in,
  input  wire                             pos_en,
  input  wire [msm_pkg::ANGLE_W-1:0]      prior_in,
  input  wire [msm_pkg::POS_W-1:0]        turn_in,
  input  wire [msm_pkg::ANGLE_W-1:0]      angle,
  output msm_pkg::pos_upd_t               upd
);
  import msm_pkg::*;

  localparam int Half  = ENCODER_COUNTS / 2;
  localparam int ErrW  = ($clog2(ENCODER_COUNTS) + 2 > ANGLE_W + 2) ?
                         $clog2(ENCODER_COUNTS) + 2 : ANGLE_W + 2;
  localparam logic signed [ErrW-1:0] HalfPos = ErrW'(Half);
  localparam logic signed [ErrW-1:0] HalfNeg = -ErrW'(Half);
  localparam logic signed [ErrW-1:0] Counts  = ErrW'(ENCODER_COUNTS);

  logic signed [ErrW-1:0] diff;
  logic signed [ErrW-1:0] err;

  always_comb begin
    diff = signed'({{(ErrW-ANGLE_W){1'b0}}, angle})
         - signed'({{(ErrW-ANGLE_W){1'b0}}, prior_in});
    if (diff > HalfPos) begin
      err = diff - Counts;
    end else if (diff < HalfNeg) begin
      err = diff + Counts;
    end else begin
      err = diff;
    end

    upd.prior_angle   = prior_in;
    upd.turn_position = turn_in;
    if (status_in == ST_OFFLINE || !pos_en) begin
      upd.turn_position = '0;
    end else if (turn_in == '0 && prior_in == '0) begin
      // first sample only latches the angle
      upd.prior_angle = angle;
    end else begin
      upd.prior_angle   = angle;
      upd.turn_position = turn_in + {{(POS_W-ErrW){err[ErrW-1]}}, err};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/motor_status_monitor_with_encoder_unwrap.sv =====
`default_nettype none

// Motor status monitor with encoder unwrap. Each request on the in_ stream
// yields exactly one result on the out_ stream, in order. A status tick
// (in_tuser = 0) classifies the motor as offline, stop, running or stall
// from the feedback age, the speed and the stall-monitored value; an angle
// sample (in_tuser = 1) folds the rotor angle into a 32-bit wrapping
// multi-turn position. Every result carries the motor state after the
// request and the current position. Throughput is one request per clock
// while out_tready is high; a request is captured in an input register,
// evaluated by a single pass of compare/add logic, and lands in the result
// register. The input register can still take a request while a result
// waits on out_tready; only when both registers are full does in_tready
// drop. Configuration writes take effect on the next clock and belong in
// idle periods; stall_limit is stored already divided by ten.
module motor_status_monitor_with_encoder_unwrap #(
  parameter int ENCODER_COUNTS = msm_pkg::ENCODER_COUNTS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // in_tdata: elapsed_ms[15:0], speed[31:16], stall_value[47:32],
  //           angle[60:48], zero[63:61]
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire [msm_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: req_type[0] (0 status tick, 1 angle sample)
  input  wire                                in_tuser,
  // out_tdata: motor_state[1:0], position[33:2], zero[39:34]
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [msm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  wire                                cfg_wr_en,
  input  wire [msm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire [msm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import msm_pkg::*;

  // stall_limit / 10 by reciprocal: exact for every 16-bit value
  function automatic logic [TICK_LIM_W-1:0] div10(input logic [CFG_DATA_W-1:0] x);
    logic [31:0] prod;
    prod = {16'd0, x} * 32'd52429;
    return prod[31:19];
  endfunction

  // ---- configuration ----
  msm_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stall_en       <= 1'b0;
      cfg_r.stall_thr      <= '0;
      cfg_r.stall_tick_lim <= '0;
      cfg_r.pos_en         <= 1'b0;
      cfg_r.offline_lim    <= OFFLINE_LIMIT_RST;
      cfg_r.stop_lim       <= STOP_SPEED_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STALL_ENABLE:     cfg_r.stall_en       <= cfg_wdata[0];
        REG_STALL_THRESHOLD:  cfg_r.stall_thr      <= cfg_wdata[LIMIT_W-1:0];
        REG_STALL_LIMIT:      cfg_r.stall_tick_lim <= div10(cfg_wdata);
        REG_POSITION_ENABLE:  cfg_r.pos_en         <= cfg_wdata[0];
        REG_OFFLINE_LIMIT:    cfg_r.offline_lim    <= cfg_wdata[MS_W-1:0];
        REG_STOP_SPEED_LIMIT: cfg_r.stop_lim       <= cfg_wdata[LIMIT_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // ---- input register ----
  logic                        in_valid_r;
  logic                        req_type_r;
  logic [MS_W-1:0]             elapsed_r;
  logic signed [SPEED_W-1:0]   speed_r;
  logic signed [SPEED_W-1:0]   sval_r;
  logic [ANGLE_W-1:0]          angle_r;

  logic out_valid_r;
  logic advance;   // request in the input register moves to the result reg

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_type_r <= in_tuser;
      elapsed_r  <= in_tdata[15:0];
      speed_r    <= in_tdata[31:16];
      sval_r     <= in_tdata[47:32];
      angle_r    <= in_tdata[60:48];
    end
  end

  // ---- motor state ----
  motor_state_t        status_r;
  logic [COUNT_W-1:0]  stall_count_r;
  logic [ANGLE_W-1:0]  prior_angle_r;
  logic [POS_W-1:0]    turn_pos_r;

  status_upd_t st_upd;
  pos_upd_t    pos_upd;

  msm_status u_status (
    .cfg            (cfg_r),
    .status_in      (status_r),
    .stall_count_in (stall_count_r),
    .elapsed_ms     (elapsed_r),
    .speed          (speed_r),
    .stall_value    (sval_r),
    .upd            (st_upd)
  );

  msm_unwrap #(
    .ENCODER_COUNTS (ENCODER_COUNTS)
  ) u_unwrap (
    .status_in (status_r),
    .pos_en    (cfg_r.pos_en),
    .prior_in  (prior_angle_r),
    .turn_in   (turn_pos_r),
    .angle     (angle_r),
    .upd       (pos_upd)
  );

  motor_state_t       status_nxt;
  logic [COUNT_W-1:0] stall_count_nxt;
  logic [ANGLE_W-1:0] prior_angle_nxt;
  logic [POS_W-1:0]   turn_pos_nxt;

  always_comb begin
    status_nxt      = status_r;
    stall_count_nxt = stall_count_r;
    prior_angle_nxt = prior_angle_r;
    turn_pos_nxt    = turn_pos_r;
    if (req_type_r) begin
      prior_angle_nxt = pos_upd.prior_angle;
      turn_pos_nxt    = pos_upd.turn_position;
    end else begin
      status_nxt      = st_upd.status;
      stall_count_nxt = st_upd.stall_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r      <= ST_OFFLINE;
      stall_count_r <= '0;
      prior_angle_r <= '0;
      turn_pos_r    <= '0;
    end else if (advance) begin
      status_r      <= status_nxt;
      stall_count_r <= stall_count_nxt;
      prior_angle_r <= prior_angle_nxt;
      turn_pos_r    <= turn_pos_nxt;
    end
  end

  // ---- result register ----
  motor_state_t     out_state_r;
  logic [POS_W-1:0] out_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state_r <= status_nxt;
      out_pos_r   <= turn_pos_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-POS_W-2){1'b0}}, out_pos_r, out_state_r};

endmodule

`default_nettype wire

// ===== rtl/msm_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module msm_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tvalid,
  input wire                             in_tready,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [msm_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import msm_pkg::*;

  // a stalled result holds
  `MSM_ASSERT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // backpressure on the input only when a result is waiting and stalled
  `MSM_ASSERT_RST(a_in_block, clk, rst_n, !in_tready |-> out_tvalid && !out_tready, "input blocked with free result slot")

  // reset empties both registers
  `MSM_ASSERT_ALWAYS(a_reset_empty, clk, rst_n && $past(!rst_n) |-> !out_tvalid && in_tready, "not empty after reset")

  // right after reset, a result appears only after some request was taken
  `MSM_ASSERT_RST(a_no_spurious, clk, rst_n, $past(!rst_n) && !in_tvalid |=> !out_tvalid, "result without request")

endmodule

bind motor_status_monitor_with_encoder_unwrap msm_checker u_msm_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import msm_pkg::*;

  // Generous ceiling: about 2100 requests, even with 65% idling on either
  // side, plus drains around each register update.
  localparam int CYCLE_LIMIT   = 400000;
  // Result register sits behind the input register; allow some slack.
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LINES  = 40;
  localparam int HALF_TURN     = ENCODER_COUNTS_DEF / 2;
  localparam int FULL_TURN     = ENCODER_COUNTS_DEF;

  // Request kinds carried on in_tuser.
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_ANGLE = 1'b1;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT ports
  // ---------------------------------------------------------------------------
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // in_tdata: elapsed_ms[15:0], speed[31:16], stall_value[47:32],
  //           angle[60:48], zero[63:61]
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  // in_tuser: req_type[0]
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // out_tdata: motor_state[1:0], position[33:2], zero[39:34]
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  always #5 clk = ~clk;

  motor_status_monitor_with_encoder_unwrap u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the monitor: register copies and state
  // ---------------------------------------------------------------------------
  logic               shadow_stall_en;
  logic [LIMIT_W-1:0] shadow_stall_thr;
  logic [15:0]        shadow_stall_lim;   // raw value, divided by ten on use
  logic               shadow_pos_en;
  logic [MS_W-1:0]    shadow_off_lim;
  logic [LIMIT_W-1:0] shadow_stop_lim;

  motor_state_t       mtr_state;
  logic [COUNT_W-1:0] stall_ticks;
  logic [ANGLE_W-1:0] last_angle;
  logic [POS_W-1:0]   turn_pos;

  typedef struct packed {
    motor_state_t     state;
    logic [POS_W-1:0] position;
  } status_report_t;

  status_report_t pending_reports[$];

  // Idle percentages for each side, changed per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          n_ticks        = 0;
  int          n_angles       = 0;
  int          n_stall        = 0;
  int          n_offline      = 0;
  int          n_unwrap       = 0;
  int          n_checked      = 0;
  logic [ANGLE_W-1:0] walk_angle = '0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] magnitude(input logic [15:0] v);
    return v[15] ? 16'(-v) : v;  // 0x8000 comes out as 32768
  endfunction

  task automatic advance_status(input logic [15:0] elapsed, input logic [15:0] speed,
                                input logic [15:0] sval);
    logic [15:0] tick_lim;
    if (elapsed > shadow_off_lim) begin
      mtr_state = ST_OFFLINE;  // stall count held across offline ticks
    end else begin
      mtr_state = (magnitude(speed) < 16'(shadow_stop_lim)) ? ST_STOP : ST_RUNNING;
      if (shadow_stall_en) begin
        if (magnitude(sval) > 16'(shadow_stall_thr) && mtr_state == ST_STOP) begin
          if (stall_ticks != 16'hFFFF) stall_ticks = stall_ticks + 16'd1;
          tick_lim = shadow_stall_lim / 16'd10;
          if (stall_ticks >= tick_lim) begin
            stall_ticks = tick_lim;
            mtr_state   = ST_STALL;
          end
        end else begin
          // quirk kept: a failed stall check reports running, even when stopped
          stall_ticks = '0;
          mtr_state   = ST_RUNNING;
        end
      end
    end
  endtask

  task automatic advance_position(input logic [ANGLE_W-1:0] angle);
    int delta;
    if (mtr_state == ST_OFFLINE || !shadow_pos_en) begin
      turn_pos = '0;                      // last_angle kept
    end else if (turn_pos == '0 && last_angle == '0) begin
      last_angle = angle;                 // first sample only latches
    end else begin
      delta = int'(angle) - int'(last_angle);
      if (delta > HALF_TURN)       delta = delta - FULL_TURN;
      else if (delta < -HALF_TURN) delta = delta + FULL_TURN;
      last_angle = angle;
      turn_pos   = turn_pos + 32'(delta);
      n_unwrap++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: gaps with in_tvalid low, then hold until accepted
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic kind, input logic [15:0] elapsed,
                              input logic [15:0] speed, input logic [15:0] sval,
                              input logic [ANGLE_W-1:0] angle);
    logic accepted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, angle, sval, speed, elapsed};
    accepted = 1'b0;
    // Inputs only move at rising edges, so the negedge view is the edge view.
    while (!accepted) begin
      @(negedge clk);
      accepted = in_tready;
      @(posedge clk);
    end
    if (kind == REQ_ANGLE) begin
      advance_position(angle);
      n_angles++;
    end else begin
      advance_status(elapsed, speed, sval);
      n_ticks++;
      if (mtr_state == ST_STALL)   n_stall++;
      if (mtr_state == ST_OFFLINE) n_offline++;
    end
    pending_reports.push_back('{state: mtr_state, position: turn_pos});
  endtask

  // Block goes idle: no request held, every result back, pipeline flushed.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_STALL_ENABLE:     shadow_stall_en  = value[0];
      REG_STALL_THRESHOLD:  shadow_stall_thr = value[LIMIT_W-1:0];
      REG_STALL_LIMIT:      shadow_stall_lim = value;
      REG_POSITION_ENABLE:  shadow_pos_en    = value[0];
      REG_OFFLINE_LIMIT:    shadow_off_lim   = value;
      REG_STOP_SPEED_LIMIT: shadow_stop_lim  = value[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and in-order checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    // keep the log short on a badly broken build; the count still grows
    if (mismatch_count <= REPORT_LINES)
      $display("[%0t] mismatch %s: got %0h, wanted %0h", $realtime, what, got, want);
  endtask

  logic                   rx_take;
  logic [OUT_TDATA_W-1:0] rx_data;
  status_report_t         rx_want;

  always begin
    @(negedge clk);
    rx_take = out_tvalid && out_tready;
    rx_data = out_tdata;
    @(posedge clk);
    if (rx_take) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected result", 32'(rx_data), '0);
      end else begin
        rx_want = pending_reports.pop_front();
        n_checked++;
        if (rx_data[1:0] != rx_want.state)
          report_mismatch("motor_state", 32'(rx_data[1:0]), 32'(rx_want.state));
        if (rx_data[33:2] != rx_want.position)
          report_mismatch("position", rx_data[33:2], rx_want.position);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_reports.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic apply_reset();
    shadow_stall_en  = 1'b0;
    shadow_stall_thr = '0;
    shadow_stall_lim = '0;
    shadow_pos_en    = 1'b0;
    shadow_off_lim   = OFFLINE_LIMIT_RST;
    shadow_stop_lim  = STOP_SPEED_RST;
    mtr_state        = ST_OFFLINE;
    stall_ticks      = '0;
    last_angle       = '0;
    turn_pos         = '0;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Reset values: 50 ms / 50 rpm limits, stall and position off.
  task automatic test_reset_defaults();
    send_request(REQ_TICK, 16'd50, 16'd49, 16'd0, '0);           // at the limit: stop
    send_request(REQ_TICK, 16'd51, 16'd0, 16'd0, '0);            // past it: offline
    send_request(REQ_ANGLE, '0, '0, '0, 13'h1FFF);               // offline angle -> 0
    send_request(REQ_TICK, 16'd0, 16'h8000, 16'h8000, '0);       // most negative speed
    send_request(REQ_TICK, 16'hFFFF, 16'hFFCE, 16'h7FFF, '0);    // -50 rpm, offline
    send_request(REQ_TICK, 16'd0, 16'hFFCE, 16'h7FFF, '0);       // -50 rpm: running
    send_request(REQ_ANGLE, '0, '0, '0, 13'd1234);               // position disabled
  endtask

  task automatic test_limit_extremes();
    wait_idle();
    write_reg(REG_OFFLINE_LIMIT, 16'd0);
    write_reg(REG_STOP_SPEED_LIMIT, 16'h7FFF);
    send_request(REQ_TICK, 16'd0, 16'h7FFF, 16'd0, '0);          // 32767 not below limit
    send_request(REQ_TICK, 16'd1, 16'd0, 16'd0, '0);             // offline
    wait_idle();
    write_reg(REG_OFFLINE_LIMIT, 16'hFFFF);
    write_reg(REG_STOP_SPEED_LIMIT, 16'd0);
    send_request(REQ_TICK, 16'hFFFF, 16'd0, 16'd0, '0);          // never offline, never stop
  endtask

  task automatic test_stall_detection();
    wait_idle();
    write_reg(REG_OFFLINE_LIMIT, 16'd1000);
    write_reg(REG_STOP_SPEED_LIMIT, 16'd50);
    write_reg(REG_STALL_THRESHOLD, 16'd100);
    write_reg(REG_STALL_LIMIT, 16'd30);                          // three ticks
    write_reg(REG_STALL_ENABLE, 16'd1);
    send_request(REQ_TICK, 16'd0, 16'd0, 16'd101, '0);
    send_request(REQ_TICK, 16'd0, 16'd0, 16'hFF9B, '0);          // -101 counts too
    send_request(REQ_TICK, 16'd0, 16'd0, 16'd101, '0);           // reaches stall
    send_request(REQ_TICK, 16'd2000, 16'd0, 16'd101, '0);        // offline keeps count
    send_request(REQ_TICK, 16'd0, 16'd0, 16'd101, '0);           // clamped, still stall
    send_request(REQ_TICK, 16'd0, 16'd0, 16'd100, '0);           // fails: forced running
    wait_idle();
    write_reg(REG_STALL_LIMIT, 16'd9);                           // limit below ten
    send_request(REQ_TICK, 16'd0, 16'd0, 16'h8000, '0);          // stall at once
    wait_idle();
    write_reg(REG_STALL_THRESHOLD, 16'h7FFF);
    write_reg(REG_STALL_LIMIT, 16'hFFFF);
    send_request(REQ_TICK, 16'd0, 16'd0, 16'h8000, '0);          // 32768 beats 32767
  endtask

  task automatic test_position_unwrap();
    wait_idle();
    write_reg(REG_STALL_ENABLE, 16'd0);
    write_reg(REG_OFFLINE_LIMIT, 16'd50);
    write_reg(REG_POSITION_ENABLE, 16'd1);
    send_request(REQ_TICK, 16'd0, 16'd1000, 16'd0, '0);          // come online
    send_request(REQ_ANGLE, '0, '0, '0, 13'd100);                // first sample latches
    send_request(REQ_ANGLE, '0, '0, '0, 13'd4196);               // +half turn, no fold
    send_request(REQ_ANGLE, '0, '0, '0, 13'd99);                 // -4097 folds forward
    send_request(REQ_ANGLE, '0, '0, '0, 13'h1FFF);               // backward across zero
    send_request(REQ_ANGLE, '0, '0, '0, 13'd0);                  // forward across zero
    send_request(REQ_TICK, 16'd51, 16'd1000, 16'd0, '0);         // tick keeps position
    send_request(REQ_ANGLE, '0, '0, '0, 13'd500);                // offline clears it
  endtask

  task automatic randomize_config();
    int unsigned r;
    r = $urandom_range(99);
    write_reg(REG_STALL_ENABLE, 16'(r < 80));
    r = $urandom_range(99);
    write_reg(REG_STALL_THRESHOLD, r < 40 ? 16'($urandom_range(2000)) :
                                   r < 50 ? 16'd0 : r < 55 ? 16'h7FFF :
                                   16'($urandom_range(16'h7FFF)));
    r = $urandom_range(99);
    write_reg(REG_STALL_LIMIT, r < 70 ? 16'($urandom_range(120)) :
                               r < 85 ? 16'($urandom_range(9)) :
                               r < 90 ? 16'hFFFF : 16'($urandom));
    r = $urandom_range(99);
    write_reg(REG_POSITION_ENABLE, 16'(r < 85));
    r = $urandom_range(99);
    write_reg(REG_OFFLINE_LIMIT, r < 70 ? 16'($urandom_range(5000, 20)) :
                                 r < 80 ? 16'd0 : r < 90 ? 16'hFFFF : 16'($urandom));
    r = $urandom_range(99);
    write_reg(REG_STOP_SPEED_LIMIT, r < 70 ? 16'($urandom_range(3000)) :
                                    r < 80 ? 16'd0 : r < 85 ? 16'h7FFF :
                                    16'($urandom_range(16'h7FFF)));
  endtask

  // Mostly online ticks near standstill with a large monitored value, so the
  // stall counter climbs; angles mostly walk in steps up to a bit past half a
  // turn, with some jumps and zero angles thrown in.
  task automatic send_random_request();
    int unsigned r;
    int unsigned mag;
    int          step;
    logic [15:0] elapsed;
    logic [15:0] speed;
    logic [15:0] sval;
    logic [ANGLE_W-1:0] angle;
    r = $urandom_range(99);
    if (r < 80)
      elapsed = 16'($urandom_range(shadow_off_lim));
    else if (r < 90 && shadow_off_lim != 16'hFFFF)
      elapsed = 16'($urandom_range(65535, int'(shadow_off_lim) + 1));
    else
      elapsed = 16'($urandom);
    if ($urandom_range(99) < 55) begin
      mag   = $urandom_range(shadow_stop_lim);
      speed = $urandom_range(1) ? 16'(-int'(mag)) : 16'(mag);
    end else begin
      speed = 16'($urandom);
    end
    if ($urandom_range(99) < 60) begin
      mag  = $urandom_range(32768, shadow_stall_thr);
      sval = $urandom_range(1) ? 16'(-int'(mag)) : 16'(mag);
    end else begin
      sval = 16'($urandom);
    end
    r = $urandom_range(99);
    if (r < 75) begin
      step       = int'($urandom_range(8400)) - 4200;
      walk_angle = ANGLE_W'(int'(walk_angle) + step);
      angle      = walk_angle;
    end else if (r < 90) begin
      angle = ANGLE_W'($urandom);
    end else begin
      angle = '0;
    end
    // fields that the request kind ignores still carry random bits
    send_request($urandom_range(1) ? REQ_ANGLE : REQ_TICK, elapsed, speed, sval, angle);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 25; recv_idle_pct = 65; end
        1:       begin send_idle_pct = 65; recv_idle_pct = 25; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        wait_idle();
        randomize_config();
        repeat (170) send_random_request();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    send_idle_pct = 25;
    recv_idle_pct = 65;
    apply_reset();
    test_reset_defaults();
    test_limit_extremes();
    test_stall_detection();
    test_position_unwrap();
    test_random_traffic();
    wait_idle();
    while (pending_reports.size() != 0) begin
      rx_want = pending_reports.pop_front();
      report_mismatch("missing result", '0, rx_want.position);
    end
    $display("Sent %0d status ticks (%0d offline, %0d in stall) and %0d angle samples",
             n_ticks, n_offline, n_stall, n_angles);
    $display("with %0d unwrap steps; %0d results checked, %0d mismatches",
             n_unwrap, n_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
